FILE: rtl/cmst_pkg.sv
`default_nettype none

package cmst_pkg;

    localparam int CMD_W      = 3;
    localparam int KEY_IN_W   = 32;
    localparam int POS_W      = 4;
    localparam int INST_OUT_W = 16;
    localparam int KEY_OUT_W  = 32;
    localparam int DIST_OUT_W = 5;
    localparam int TOT_OUT_W  = 20;

    localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ERASE     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ERASE_ALL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_COUNT     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_GET       = 3'd4;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/counting_multiset_table_unit.sv
`default_nettype none

// Counting multiset of up to CAPACITY distinct keys, kept in insertion order, each with an
// instance count. One command is worked at a time. Insert, erase, erase-all and count walk
// the stored keys through a single comparator at one entry a cycle. An erase that empties
// an entry, and every erase-all that hits, then moves the later entries down one place
// through the same read port. Get reads its position directly, without a scan. s_ready is
// high only between commands; a finished result waits in the output register while the
// next command is taken. The key memory needs no clearing after reset: only positions
// below the distinct count are ever read.
module counting_multiset_table_unit #(
    parameter int CAPACITY    = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [cmst_pkg::CMD_W-1:0]        s_command,
    input  wire logic [cmst_pkg::KEY_IN_W-1:0]     s_key,
    input  wire logic [cmst_pkg::POS_W-1:0]        s_position,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_accepted,
    output logic                                   m_found,
    output logic      [cmst_pkg::INST_OUT_W-1:0]   m_instances,
    output logic      [cmst_pkg::KEY_OUT_W-1:0]    m_key_out,
    output logic      [cmst_pkg::DIST_OUT_W-1:0]   m_distinct_count,
    output logic      [cmst_pkg::TOT_OUT_W-1:0]    m_total_count
);

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int TOT_W  = CNT_W + COUNT_WIDTH;
    localparam int KW_MAX = (KEY_WIDTH > cmst_pkg::KEY_IN_W) ? KEY_WIDTH : cmst_pkg::KEY_IN_W;
    localparam int PW     = (CNT_W > cmst_pkg::POS_W) ? CNT_W : cmst_pkg::POS_W;
    localparam int IW_MAX = (COUNT_WIDTH > cmst_pkg::INST_OUT_W) ? COUNT_WIDTH
                                                                 : cmst_pkg::INST_OUT_W;
    localparam int DW_MAX = (CNT_W > cmst_pkg::DIST_OUT_W) ? CNT_W : cmst_pkg::DIST_OUT_W;
    localparam int TW_MAX = (TOT_W > cmst_pkg::TOT_OUT_W) ? TOT_W : cmst_pkg::TOT_OUT_W;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_FETCH = 6'b000100,
        ST_APPLY = 6'b001000,
        ST_SHIFT = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t                            state_reg, state_next;
    logic [cmst_pkg::CMD_W-1:0]        cmd_reg, cmd_next;
    logic [KEY_WIDTH-1:0]              key_reg, key_next;
    logic [cmst_pkg::POS_W-1:0]        pos_reg, pos_next;
    logic [CNT_W-1:0]                  distinct_reg, distinct_next;
    logic [TOT_W-1:0]                  total_reg, total_next;
    logic [CNT_W-1:0]                  cnt_reg, cnt_next;
    logic                              pend_reg, pend_next;
    logic [IDX_W-1:0]                  pend_idx_reg, pend_idx_next;
    logic                              hit_reg, hit_next;
    logic [IDX_W-1:0]                  hit_idx_reg, hit_idx_next;
    logic                              pos_ok_reg, pos_ok_next;
    logic                              res_acc_reg, res_acc_next;
    logic                              res_found_reg, res_found_next;
    logic [COUNT_WIDTH-1:0]            res_inst_reg, res_inst_next;
    logic [KEY_WIDTH-1:0]              res_key_reg, res_key_next;
    logic                              m_valid_reg;

    cmst_pkg::mem_ctrl_t               mem_ctrl;
    logic [IDX_W-1:0]                  rd_addr, wr_addr;
    logic [KEY_WIDTH-1:0]              wr_key, rd_key;
    logic [COUNT_WIDTH-1:0]            wr_count, rd_count;
    logic                              match;

    logic [KW_MAX-1:0]                 key_in_ext, key_out_ext;
    logic [PW-1:0]                     pos_ext, dist_ext;
    logic [IW_MAX-1:0]                 inst_ext;
    logic [DW_MAX-1:0]                 dist_out_ext;
    logic [TW_MAX-1:0]                 tot_out_ext;
    logic                              out_free;

    cmst_entry_store #(
        .DEPTH (CAPACITY),
        .KEY_W (KEY_WIDTH),
        .CNT_W (COUNT_WIDTH)
    ) u_store (
        .aclk     (aclk),
        .ctrl     (mem_ctrl),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr_key   (wr_key),
        .wr_count (wr_count),
        .cmp_key  (key_reg),
        .rd_key   (rd_key),
        .rd_count (rd_count),
        .match    (match)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        key_in_ext   = KW_MAX'(s_key);
        key_out_ext  = KW_MAX'(res_key_reg);
        pos_ext      = PW'(pos_reg);
        dist_ext     = PW'(distinct_reg);
        inst_ext     = IW_MAX'(res_inst_reg);
        dist_out_ext = DW_MAX'(distinct_reg);
        tot_out_ext  = TW_MAX'(total_reg);
    end

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        pos_next       = pos_reg;
        distinct_next  = distinct_reg;
        total_next     = total_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        pos_ok_next    = pos_ok_reg;
        res_acc_next   = res_acc_reg;
        res_found_next = res_found_reg;
        res_inst_next  = res_inst_reg;
        res_key_next   = res_key_reg;
        mem_ctrl       = '0;
        rd_addr        = '0;
        wr_addr        = '0;
        wr_key         = key_reg;
        wr_count       = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next  = s_command;
                    key_next  = key_in_ext[KEY_WIDTH-1:0];
                    pos_next  = s_position;
                    cnt_next  = '0;
                    pend_next = 1'b0;
                    hit_next  = 1'b0;
                    pos_ok_next = 1'b0;
                    if (s_command == cmst_pkg::CMD_GET) begin
                        state_next = ST_FETCH;
                    end else if (s_command == cmst_pkg::CMD_INSERT
                              || s_command == cmst_pkg::CMD_ERASE
                              || s_command == cmst_pkg::CMD_ERASE_ALL
                              || s_command == cmst_pkg::CMD_COUNT) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_APPLY;
                    end
                end
            end
            ST_SCAN: begin
                if (pend_reg && match) begin
                    hit_next     = 1'b1;
                    hit_idx_next = pend_idx_reg;
                    pend_next    = 1'b0;
                    state_next   = ST_APPLY;
                end else if (cnt_reg < distinct_reg) begin
                    mem_ctrl.rd_en = 1'b1;
                    rd_addr        = cnt_reg[IDX_W-1:0];
                    pend_next      = 1'b1;
                    pend_idx_next  = cnt_reg[IDX_W-1:0];
                    cnt_next       = cnt_reg + CNT_W'(1);
                end else begin
                    pend_next  = 1'b0;
                    state_next = ST_APPLY;
                end
            end
            ST_FETCH: begin
                if (pos_ext < dist_ext) begin
                    mem_ctrl.rd_en = 1'b1;
                    rd_addr        = pos_ext[IDX_W-1:0];
                    pos_ok_next    = 1'b1;
                end
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                res_acc_next   = 1'b0;
                res_found_next = 1'b0;
                res_inst_next  = '0;
                res_key_next   = '0;
                state_next     = ST_DONE;
                unique case (cmd_reg)
                    cmst_pkg::CMD_INSERT: begin
                        if (hit_reg) begin
                            res_found_next = 1'b1;
                            if (!(&rd_count)) begin
                                mem_ctrl.wr_en = 1'b1;
                                wr_addr        = hit_idx_reg;
                                wr_count       = rd_count + COUNT_WIDTH'(1);
                                total_next     = total_reg + TOT_W'(1);
                                res_acc_next   = 1'b1;
                                res_inst_next  = rd_count + COUNT_WIDTH'(1);
                            end else begin
                                res_inst_next = rd_count;
                            end
                        end else if (distinct_reg < CAP_C) begin
                            mem_ctrl.wr_en = 1'b1;
                            wr_addr        = distinct_reg[IDX_W-1:0];
                            wr_count       = COUNT_WIDTH'(1);
                            distinct_next  = distinct_reg + CNT_W'(1);
                            total_next     = total_reg + TOT_W'(1);
                            res_acc_next   = 1'b1;
                            res_inst_next  = COUNT_WIDTH'(1);
                        end
                    end
                    cmst_pkg::CMD_ERASE: begin
                        if (hit_reg) begin
                            res_found_next = 1'b1;
                            res_inst_next  = COUNT_WIDTH'(1);
                            total_next     = total_reg - TOT_W'(1);
                            if (rd_count > COUNT_WIDTH'(1)) begin
                                mem_ctrl.wr_en = 1'b1;
                                wr_addr        = hit_idx_reg;
                                wr_count       = rd_count - COUNT_WIDTH'(1);
                            end else begin
                                cnt_next   = CNT_W'(hit_idx_reg) + CNT_W'(1);
                                pend_next  = 1'b0;
                                state_next = ST_SHIFT;
                            end
                        end
                    end
                    cmst_pkg::CMD_ERASE_ALL: begin
                        if (hit_reg) begin
                            res_found_next = 1'b1;
                            res_inst_next  = rd_count;
                            total_next     = total_reg - TOT_W'(rd_count);
                            cnt_next       = CNT_W'(hit_idx_reg) + CNT_W'(1);
                            pend_next      = 1'b0;
                            state_next     = ST_SHIFT;
                        end
                    end
                    cmst_pkg::CMD_COUNT: begin
                        if (hit_reg) begin
                            res_found_next = 1'b1;
                            res_inst_next  = rd_count;
                        end
                    end
                    cmst_pkg::CMD_GET: begin
                        if (pos_ok_reg) begin
                            res_found_next = 1'b1;
                            res_inst_next  = rd_count;
                            res_key_next   = rd_key;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_SHIFT: begin
                if (pend_reg) begin
                    mem_ctrl.wr_en = 1'b1;
                    wr_addr        = pend_idx_reg - IDX_W'(1);
                    wr_key         = rd_key;
                    wr_count       = rd_count;
                end
                if (cnt_reg < distinct_reg) begin
                    mem_ctrl.rd_en = 1'b1;
                    rd_addr        = cnt_reg[IDX_W-1:0];
                    pend_next      = 1'b1;
                    pend_idx_next  = cnt_reg[IDX_W-1:0];
                    cnt_next       = cnt_reg + CNT_W'(1);
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        distinct_next = distinct_reg - CNT_W'(1);
                        state_next    = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            distinct_reg <= '0;
            total_reg    <= '0;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            hit_reg      <= 1'b0;
            pos_ok_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            distinct_reg <= distinct_next;
            total_reg    <= total_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            hit_reg      <= hit_next;
            pos_ok_reg   <= pos_ok_next;
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        key_reg       <= key_next;
        pos_reg       <= pos_next;
        pend_idx_reg  <= pend_idx_next;
        hit_idx_reg   <= hit_idx_next;
        res_acc_reg   <= res_acc_next;
        res_found_reg <= res_found_next;
        res_inst_reg  <= res_inst_next;
        res_key_reg   <= res_key_next;
        // load the result beat once the output register is free
        if (state_reg == ST_DONE && out_free) begin
            m_accepted       <= res_acc_reg;
            m_found          <= res_found_reg;
            m_instances      <= inst_ext[cmst_pkg::INST_OUT_W-1:0];
            m_key_out        <= key_out_ext[cmst_pkg::KEY_OUT_W-1:0];
            m_distinct_count <= dist_out_ext[cmst_pkg::DIST_OUT_W-1:0];
            m_total_count    <= tot_out_ext[cmst_pkg::TOT_OUT_W-1:0];
        end
    end

    a_distinct_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        distinct_reg <= CAP_C)
        else $error("distinct count above capacity");

    a_total_covers_distinct: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_SHIFT) |-> (TW_MAX'(distinct_reg) <= TW_MAX'(total_reg)))
        else $error("total count below distinct count");

    a_write_when_working: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_ctrl.wr_en |-> (state_reg == ST_APPLY || state_reg == ST_SHIFT))
        else $error("entry write outside apply or shift");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second command taken while busy");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=> (m_valid && state_reg == ST_IDLE))
        else $error("result beat not presented");

endmodule

`default_nettype wire

FILE: rtl/cmst_entry_store.sv
`default_nettype none

module cmst_entry_store #(
    parameter int DEPTH = 16,
    parameter int KEY_W = 32,
    parameter int CNT_W = 16
) (
    input  wire logic                     aclk,
    input  wire cmst_pkg::mem_ctrl_t      ctrl,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [KEY_W-1:0]         wr_key,
    input  wire logic [CNT_W-1:0]         wr_count,
    input  wire logic [KEY_W-1:0]         cmp_key,
    output logic      [KEY_W-1:0]         rd_key,
    output logic      [CNT_W-1:0]         rd_count,
    output logic                          match
);

    logic [KEY_W+CNT_W-1:0] mem [DEPTH];
    logic [KEY_W+CNT_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[wr_addr] <= {wr_key, wr_count};
        end
        if (ctrl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_key   = rd_data_reg[KEY_W+CNT_W-1:CNT_W];
    assign rd_count = rd_data_reg[CNT_W-1:0];
    assign match    = (rd_key == cmp_key);

endmodule

`default_nettype wire

FILE: tb/tb_counting_multiset_table_unit.sv
`timescale 1ns / 1ps

module tb_counting_multiset_table_unit;

    localparam int TABLE_DEPTH = 16;
    localparam int COUNT_MAX = 65535;
    localparam logic [cmst_pkg::CMD_W-1:0] CMD_TOP = 3'd7;
    localparam int IDLE_LIMIT = 5000;
    localparam int LONG_HOLD = 400;
    localparam int POOL_SIZE = 24;
    localparam int MAX_PRINTED = 50;
    localparam int RANDOM_PER_PHASE = 220;
    localparam int REPEAT_INSERTS = 12;

    typedef struct packed {
        logic                            accepted;
        logic                            found;
        logic [cmst_pkg::INST_OUT_W-1:0] instances;
        logic [cmst_pkg::KEY_OUT_W-1:0]  key_out;
        logic [cmst_pkg::DIST_OUT_W-1:0] distinct;
        logic [cmst_pkg::TOT_OUT_W-1:0]  total;
    } result_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    logic [cmst_pkg::CMD_W-1:0]      s_command;
    logic [cmst_pkg::KEY_IN_W-1:0]   s_key;
    logic [cmst_pkg::POS_W-1:0]      s_position;
    logic                            m_valid;
    logic                            m_ready;
    logic                            m_accepted;
    logic                            m_found;
    logic [cmst_pkg::INST_OUT_W-1:0] m_instances;
    logic [cmst_pkg::KEY_OUT_W-1:0]  m_key_out;
    logic [cmst_pkg::DIST_OUT_W-1:0] m_distinct_count;
    logic [cmst_pkg::TOT_OUT_W-1:0]  m_total_count;

    logic [cmst_pkg::KEY_IN_W-1:0] held_key [TABLE_DEPTH];
    int unsigned                   held_count [TABLE_DEPTH];
    int unsigned                   held_distinct;
    int unsigned                   held_total;
    logic [cmst_pkg::KEY_IN_W-1:0] key_pool [POOL_SIZE];

    result_t awaited_results[$];
    int      error_count = 0;
    int      quiet_cycles = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      hold_requests = 0;
    int      hold_taken = 0;
    int      hold_left = 0;

    counting_multiset_table_unit DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_key            (s_key),
        .s_position       (s_position),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_accepted       (m_accepted),
        .m_found          (m_found),
        .m_instances      (m_instances),
        .m_key_out        (m_key_out),
        .m_distinct_count (m_distinct_count),
        .m_total_count    (m_total_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int find_slot(input logic [cmst_pkg::KEY_IN_W-1:0] key);
        for (int i = 0; i < held_distinct; i++) begin
            if (held_key[i] == key) begin
                return i;
            end
        end
        return TABLE_DEPTH;
    endfunction

    function automatic void drop_slot(input int idx);
        for (int i = idx; i + 1 < held_distinct; i++) begin
            held_key[i]   = held_key[i + 1];
            held_count[i] = held_count[i + 1];
        end
        held_distinct--;
        held_key[held_distinct]   = '0;
        held_count[held_distinct] = 0;
    endfunction

    function automatic result_t apply_command(input logic [cmst_pkg::CMD_W-1:0] cmd,
                                              input logic [cmst_pkg::KEY_IN_W-1:0] key,
                                              input logic [cmst_pkg::POS_W-1:0] pos);
        result_t r = '0;
        int slot = find_slot(key);
        case (cmd)
            cmst_pkg::CMD_INSERT: begin
                if (slot < TABLE_DEPTH) begin
                    r.found = 1'b1;
                    if (held_count[slot] < COUNT_MAX) begin
                        held_count[slot]++;
                        held_total++;
                        r.accepted = 1'b1;
                    end
                    r.instances = cmst_pkg::INST_OUT_W'(held_count[slot]);
                end else if (held_distinct < TABLE_DEPTH) begin
                    held_key[held_distinct]   = key;
                    held_count[held_distinct] = 1;
                    held_distinct++;
                    held_total++;
                    r.accepted  = 1'b1;
                    r.instances = cmst_pkg::INST_OUT_W'(1);
                end
            end
            cmst_pkg::CMD_ERASE: begin
                if (slot < TABLE_DEPTH) begin
                    r.found     = 1'b1;
                    r.instances = cmst_pkg::INST_OUT_W'(1);
                    held_count[slot]--;
                    held_total--;
                    if (held_count[slot] == 0) begin
                        drop_slot(slot);
                    end
                end
            end
            cmst_pkg::CMD_ERASE_ALL: begin
                if (slot < TABLE_DEPTH) begin
                    r.found     = 1'b1;
                    r.instances = cmst_pkg::INST_OUT_W'(held_count[slot]);
                    held_total -= held_count[slot];
                    drop_slot(slot);
                end
            end
            cmst_pkg::CMD_COUNT: begin
                if (slot < TABLE_DEPTH) begin
                    r.found     = 1'b1;
                    r.instances = cmst_pkg::INST_OUT_W'(held_count[slot]);
                end
            end
            cmst_pkg::CMD_GET: begin
                if (pos < held_distinct) begin
                    r.found     = 1'b1;
                    r.instances = cmst_pkg::INST_OUT_W'(held_count[pos]);
                    r.key_out   = held_key[pos];
                end
            end
            default: begin
            end
        endcase
        r.distinct = cmst_pkg::DIST_OUT_W'(held_distinct);
        r.total    = cmst_pkg::TOT_OUT_W'(held_total);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected beat", '0, '0);
            end else begin
                want = awaited_results.pop_front();
                if (m_accepted !== want.accepted)
                    report_mismatch("accepted", 32'(m_accepted), 32'(want.accepted));
                if (m_found !== want.found)
                    report_mismatch("found", 32'(m_found), 32'(want.found));
                if (m_instances !== want.instances)
                    report_mismatch("instances", 32'(m_instances), 32'(want.instances));
                if (m_key_out !== want.key_out)
                    report_mismatch("key_out", m_key_out, want.key_out);
                if (m_distinct_count !== want.distinct)
                    report_mismatch("distinct_count", 32'(m_distinct_count),
                                    32'(want.distinct));
                if (m_total_count !== want.total)
                    report_mismatch("total_count", 32'(m_total_count), 32'(want.total));
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= IDLE_LIMIT) begin
                    $display("FAILURE");
                    $finish;
                end
            end
        end
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_requests != hold_taken) begin
                hold_taken = hold_requests;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else begin
                m_ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_command(input logic [cmst_pkg::CMD_W-1:0] cmd,
                                input logic [cmst_pkg::KEY_IN_W-1:0] key,
                                input logic [cmst_pkg::POS_W-1:0] pos);
        s_valid    = 1'b1;
        s_command  = cmd;
        s_key      = key;
        s_position = pos;
        do @(posedge aclk); while (!s_ready);
        awaited_results.push_back(apply_command(cmd, key, pos));
        @(negedge aclk);
        s_valid = 1'b0;
        if ($urandom_range(99) < send_idle_pct) begin
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
    endtask

    function automatic logic [cmst_pkg::KEY_IN_W-1:0] pick_key();
        if ($urandom_range(99) < 85) begin
            return key_pool[$urandom_range(POOL_SIZE - 1)];
        end
        return $urandom();
    endfunction

    function automatic logic [cmst_pkg::CMD_W-1:0] pick_command();
        int roll = $urandom_range(99);
        if (roll < 40) return cmst_pkg::CMD_INSERT;
        if (roll < 60) return cmst_pkg::CMD_ERASE;
        if (roll < 68) return cmst_pkg::CMD_ERASE_ALL;
        if (roll < 80) return cmst_pkg::CMD_COUNT;
        if (roll < 95) return cmst_pkg::CMD_GET;
        return cmst_pkg::CMD_W'(cmst_pkg::CMD_GET + 1
                                + $urandom_range(CMD_TOP - cmst_pkg::CMD_GET - 1));
    endfunction

    function automatic logic [cmst_pkg::POS_W-1:0] pick_position();
        if (held_distinct > 0 && $urandom_range(99) < 70) begin
            return cmst_pkg::POS_W'($urandom_range(held_distinct - 1));
        end
        return cmst_pkg::POS_W'($urandom_range(TABLE_DEPTH - 1));
    endfunction

    task automatic send_random();
        send_command(pick_command(), pick_key(), pick_position());
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_command(cmst_pkg::CMD_COUNT, 32'h0000_0000, '0);
        send_command(cmst_pkg::CMD_ERASE, 32'h1234_5678, '0);
        send_command(cmst_pkg::CMD_ERASE_ALL, 32'hFFFF_FFFF, '0);
        send_command(cmst_pkg::CMD_GET, '0, '0);
        for (int c = cmst_pkg::CMD_GET + 1; c <= CMD_TOP; c++) begin
            send_command(cmst_pkg::CMD_W'(c), 32'hFFFF_FFFF, '1);
        end
        send_command(cmst_pkg::CMD_INSERT, 32'h0000_0000, '0);
        send_command(cmst_pkg::CMD_INSERT, 32'hFFFF_FFFF, '0);
        send_command(cmst_pkg::CMD_INSERT, 32'h0000_0000, '0);
        send_command(cmst_pkg::CMD_COUNT, 32'h0000_0000, '0);
        send_command(cmst_pkg::CMD_GET, '0, 4'd0);
        send_command(cmst_pkg::CMD_GET, '0, 4'd1);
        send_command(cmst_pkg::CMD_GET, '0, 4'd2);
        send_command(cmst_pkg::CMD_GET, '0, '1);
        send_command(cmst_pkg::CMD_ERASE, 32'h0000_0000, '0);
        send_command(cmst_pkg::CMD_ERASE, 32'h0000_0000, '0);
        send_command(cmst_pkg::CMD_GET, '0, 4'd0);
        send_command(cmst_pkg::CMD_ERASE_ALL, 32'hFFFF_FFFF, '0);
        for (int c = cmst_pkg::CMD_GET + 1; c <= CMD_TOP; c++) begin
            send_command(cmst_pkg::CMD_W'(c), 32'h0000_0000, '0);
        end
    endtask

    task automatic test_table_full();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            send_command(cmst_pkg::CMD_INSERT, 32'h1000_0000 + i * 32'h0111_1111, '0);
        end
        send_command(cmst_pkg::CMD_INSERT, 32'hDEAD_BEEF, '0);
        send_command(cmst_pkg::CMD_INSERT, 32'h1000_0000, '0);
        send_command(cmst_pkg::CMD_GET, '0, '1);
        send_command(cmst_pkg::CMD_ERASE_ALL, held_key[5], '0);
        send_command(cmst_pkg::CMD_GET, '0, 4'd5);
        send_command(cmst_pkg::CMD_GET, '0, '1);
        send_command(cmst_pkg::CMD_INSERT, 32'hDEAD_BEEF, '0);
        send_command(cmst_pkg::CMD_GET, '0, '1);
        send_command(cmst_pkg::CMD_ERASE, held_key[0], '0);
        send_command(cmst_pkg::CMD_ERASE, held_key[0], '0);
        send_command(cmst_pkg::CMD_ERASE, held_key[0], '0);
        while (held_distinct > 0) begin
            send_command(cmst_pkg::CMD_ERASE_ALL, held_key[held_distinct - 1], '0);
        end
    endtask

    task automatic test_repeated_key();
        logic [cmst_pkg::KEY_IN_W-1:0] key = 32'h5A5A_A5A5;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (REPEAT_INSERTS) send_command(cmst_pkg::CMD_INSERT, key, '0);
        send_command(cmst_pkg::CMD_COUNT, key, '0);
        send_command(cmst_pkg::CMD_GET, '0, '0);
        send_command(cmst_pkg::CMD_ERASE, key, '0);
        send_command(cmst_pkg::CMD_INSERT, key, '0);
        send_command(cmst_pkg::CMD_ERASE_ALL, key, '0);
    endtask

    task automatic test_random(input int items, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (items) send_random();
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge aclk);
        hold_requests++;
        @(negedge aclk);
        repeat (20) send_random();
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_command     = cmst_pkg::CMD_INSERT;
        s_key         = '0;
        s_position    = '0;
        held_distinct = 0;
        held_total    = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            held_key[i]   = '0;
            held_count[i] = 0;
        end
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom();
        end
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_table_full();
        test_repeated_key();
        test_random(RANDOM_PER_PHASE, 0, 0);
        test_random(RANDOM_PER_PHASE, 66, 0);
        test_backpressure();
        test_random(RANDOM_PER_PHASE, 0, 66);
        test_random(RANDOM_PER_PHASE, 27, 27);

        wait (awaited_results.size() == 0);
        repeat (60) @(posedge aclk);
        if (error_count == 0 && awaited_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
